FILE: sv/frl_pkg.sv
// ---------------------------------------------------------------------------
// frl_pkg: shared types and constants for the Fresnel reflectance pipeline
// Word layouts of both channels, fixed-point widths and unit constants.
// ---------------------------------------------------------------------------
package frl_pkg;

  localparam int CFRAC = 30;               // fraction bits of sines and cosines
  localparam int CW    = 31;               // Q.30 cosine, up to and including 1.0
  localparam int EW    = 14;               // refractive index width, Q2.12
  localparam int EFRAC = 12;

  localparam logic [EW-1:0] ONE_IDX = 14'd4096;
  localparam logic [CW-1:0] ONE_Q30 = {1'b1, {CFRAC{1'b0}}};
  localparam logic [61:0]   ONE_Q60 = 62'd1 << 60;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [13:0]        refr_index;
  } in_word_t;

  typedef struct packed {
    logic [15:0] reflectance;
    logic        total_internal;
  } out_word_t;

  // cosine of incidence and the two indices, carried beside the long units
  typedef struct packed {
    logic [CW-1:0] ci;
    logic [EW-1:0] etai;
    logic [EW-1:0] etat;
  } eta_t;

endpackage

FILE: sv/frl_isqrt.sv
// ---------------------------------------------------------------------------
// frl_isqrt: pipelined integer square root
// Floor square root, one result bit per register stage, sideband in step.
// ---------------------------------------------------------------------------
module frl_isqrt #(
  parameter int RW  = 31,
  parameter int SBW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [2*RW-1:0] rad,
  input  logic [SBW-1:0]  in_sb,
  output logic            out_vld,
  output logic [RW-1:0]   root,
  output logic [SBW-1:0]  out_sb
);
  localparam int REMW = RW + 2;

  logic [REMW-1:0] rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] rad_q  [RW];
  logic [SBW-1:0]  sb_q   [RW];
  logic [RW-1:0]   vld_q;

  logic [REMW-1:0] rem_i  [RW];
  logic [RW-1:0]   root_i [RW];
  logic [2*RW-1:0] rad_i  [RW];
  logic [SBW-1:0]  sb_i   [RW];
  logic [RW-1:0]   vld_i;

  logic [REMW+1:0] cur [RW];
  logic [REMW+1:0] dif [RW];
  logic [RW-1:0]   ge;

  always_comb begin
    rem_i[0]  = '0;
    root_i[0] = '0;
    rad_i[0]  = rad;
    sb_i[0]   = in_sb;
    vld_i[0]  = in_vld;
    for (int k = 1; k < RW; k++) begin
      rem_i[k]  = rem_q[k-1];
      root_i[k] = root_q[k-1];
      rad_i[k]  = rad_q[k-1] << 2;
      sb_i[k]   = sb_q[k-1];
      vld_i[k]  = vld_q[k-1];
    end
    for (int k = 0; k < RW; k++) begin
      cur[k] = {rem_i[k], rad_i[k][2*RW-1 -: 2]};
      dif[k] = cur[k] - {2'b00, root_i[k], 2'b01};
      ge[k]  = cur[k] >= {2'b00, root_i[k], 2'b01};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RW; k++) begin
        rem_q[k]  <= ge[k] ? dif[k][REMW-1:0] : cur[k][REMW-1:0];
        root_q[k] <= {root_i[k][RW-2:0], ge[k]};
        rad_q[k]  <= rad_i[k];
        sb_q[k]   <= sb_i[k];
      end
    end
  end

  assign out_vld = vld_q[RW-1];
  assign root    = root_q[RW-1];
  assign out_sb  = sb_q[RW-1];

endmodule

FILE: sv/frl_div.sv
// ---------------------------------------------------------------------------
// frl_div: pipelined restoring divider
// Starts from a partial remainder below twice the divisor, then shifts in
// SW more dividend bits; one quotient bit per register stage.
// ---------------------------------------------------------------------------
module frl_div #(
  parameter int DW  = 14,
  parameter int SW  = 31,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  logic [DW-1:0]  den,
  input  logic [DW:0]    rem0,
  input  logic [SW-1:0]  low,
  input  logic [SBW-1:0] in_sb,
  output logic           out_vld,
  output logic [SW:0]    quo,
  output logic [SBW-1:0] out_sb
);
  localparam int NS = SW + 1;

  logic [DW-1:0]  rem_q [NS];
  logic [DW-1:0]  den_q [NS];
  logic [SW-1:0]  low_q [NS];
  logic [SW:0]    quo_q [NS];
  logic [SBW-1:0] sb_q  [NS];
  logic [NS-1:0]  vld_q;

  logic [DW:0]    cur_i [NS];
  logic [DW-1:0]  den_i [NS];
  logic [SW-1:0]  low_i [NS];
  logic [SW:0]    quo_i [NS];
  logic [SBW-1:0] sb_i  [NS];
  logic [NS-1:0]  vld_i;
  logic [DW:0]    dif   [NS];
  logic [NS-1:0]  ge;

  always_comb begin
    cur_i[0] = rem0;
    den_i[0] = den;
    low_i[0] = low;
    quo_i[0] = '0;
    sb_i[0]  = in_sb;
    vld_i[0] = in_vld;
    for (int k = 1; k < NS; k++) begin
      cur_i[k] = {rem_q[k-1], low_q[k-1][SW-1]};
      den_i[k] = den_q[k-1];
      low_i[k] = low_q[k-1] << 1;
      quo_i[k] = quo_q[k-1];
      sb_i[k]  = sb_q[k-1];
      vld_i[k] = vld_q[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      dif[k] = cur_i[k] - {1'b0, den_i[k]};
      ge[k]  = cur_i[k] >= {1'b0, den_i[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        rem_q[k] <= ge[k] ? dif[k][DW-1:0] : cur_i[k][DW-1:0];
        den_q[k] <= den_i[k];
        low_q[k] <= low_i[k];
        quo_q[k] <= {quo_i[k][SW-1:0], ge[k]};
        sb_q[k]  <= sb_i[k];
      end
    end
  end

  assign out_vld = vld_q[NS-1];
  assign quo     = quo_q[NS-1];
  assign out_sb  = sb_q[NS-1];

endmodule

FILE: sv/frl_skid.sv
// ---------------------------------------------------------------------------
// frl_skid: output register with skid entry
// Keeps ready registered; the pipeline freezes only while the skid is full.
// ---------------------------------------------------------------------------
module frl_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  frl_pkg::out_word_t in_word,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_ready,
  output frl_pkg::out_word_t out_word
);
  import frl_pkg::*;

  out_word_t hold;
  logic      hold_vld;

  assign ready = ~hold_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hold_vld  <= 1'b0;
    end else if (hold_vld) begin
      if (out_ready) begin
        hold_vld <= 1'b0;
      end
    end else if (in_vld) begin
      if (out_valid && !out_ready) begin
        hold_vld <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_vld) begin
      if (out_ready) begin
        out_word <= hold;
      end
    end else if (in_vld) begin
      if (out_valid && !out_ready) begin
        hold <= in_word;
      end else begin
        out_word <= in_word;
      end
    end
  end

endmodule

FILE: sv/fresnel_reflectance.sv
// ---------------------------------------------------------------------------
// fresnel_reflectance: unpolarized Fresnel reflectance, fixed point
// Ray direction and normal (Q1.14) plus object index (Q2.12) in, reflected
// fraction (Q1.15, saturating at 1.0) and a total-internal flag out.
// ---------------------------------------------------------------------------
// Usage
//   Input channel in_valid/in_ready/in_word carries one word per ray hit;
//   output channel out_valid/out_ready/out_word returns one word per input,
//   in order. A word moves when valid and ready are both high at a clock edge.
//   Throughput: one word per cycle, sustained while the skid entry is empty.
//   Most of the pipeline depth lies in the long units: two square roots
//   of 31 stages each, the Snell divider of 32 stages and the Rs/Rp
//   dividers of 31 stages, one result bit per stage.
//   Stalls: the whole pipeline shares one enable. A result that arrives while
//   the output register is still held goes to a skid entry; while that entry
//   is full, in_ready is low and every stage holds. Nothing is dropped.
//   in_ready is a register output, no path from out_ready to in_ready.
//   Reset (rst, synchronous): clears all valid bits, out_valid included, not the data;
//   in_ready is high on the first cycle after reset. No state is kept.
// ---------------------------------------------------------------------------
module fresnel_reflectance #(
  parameter int VEC_FRAC_BITS = 14,
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  frl_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output frl_pkg::out_word_t out_word
);
  import frl_pkg::*;

  // dot product scaling into Q.30
  localparam int DSH = 2 * VEC_FRAC_BITS;
  localparam int SHR = (DSH >= CFRAC) ? DSH - CFRAC : 0;
  localparam int SHL = (DSH < CFRAC) ? CFRAC - DSH : 0;
  localparam logic [63:0] ONE_D = 64'd1 << DSH;
  // Q.60 mean of squares down to the output format
  localparam int RSH = 60 - OUT_FRAC_BITS;
  localparam logic [63:0] ONE_OUT  = 64'd1 << OUT_FRAC_BITS;
  localparam logic [63:0] HALF_LSB = 64'd1 << (RSH - 1);

  logic en;   // pipeline advance, low only while the skid entry is full

  // ---- S1: three component products, index floor at 1.0 ----
  logic signed [31:0] px1, py1, pz1;
  logic [EW-1:0]      n1;
  logic               v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= in_word.dir_x * in_word.norm_x;
      py1 <= in_word.dir_y * in_word.norm_y;
      pz1 <= in_word.dir_z * in_word.norm_z;
      n1  <= (in_word.refr_index < ONE_IDX) ? ONE_IDX : in_word.refr_index;
    end
  end

  // ---- S2: dot product ----
  logic signed [33:0] dot2;
  logic [EW-1:0]      n2;
  logic               v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot2 <= 34'(px1) + 34'(py1) + 34'(pz1);
      n2   <= n1;
    end
  end

  // ---- S3: clamp |cos| to 1.0, move to Q.30, pick index order ----
  // positive cosine: ray is leaving the object, indices swap
  logic          leaving;
  logic [33:0]   mag;
  logic [63:0]   mag64, magc, cis;
  eta_t          eta3_next, eta3;
  logic          v3;

  always_comb begin
    leaving = dot2 > 34'sd0;
    mag     = dot2[33] ? 34'(-dot2) : 34'(dot2);
    mag64   = {30'd0, mag};
    magc    = (mag64 > ONE_D) ? ONE_D : mag64;
    cis     = (magc >> SHR) << SHL;
    eta3_next.ci   = (cis > {33'd0, ONE_Q30}) ? ONE_Q30 : cis[CW-1:0];
    eta3_next.etai = leaving ? n2 : ONE_IDX;
    eta3_next.etat = leaving ? ONE_IDX : n2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eta3 <= eta3_next;
    end
  end

  // ---- S4, S5: 1 - cos^2 in Q.60 ----
  logic [61:0] cisq4, rad5;
  eta_t        eta4, eta5;
  logic        v4, v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cisq4 <= 62'(eta3.ci) * 62'(eta3.ci);
      eta4  <= eta3;
      rad5  <= ONE_Q60 - cisq4;
      eta5  <= eta4;
    end
  end

  // ---- incident sine ----
  logic [CW-1:0] sini;
  eta_t          eta_si;
  logic          v_si;

  frl_isqrt #(
    .RW  (CW),
    .SBW ($bits(eta_t))
  ) u_sqrt_sin (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v5),
    .rad     (rad5),
    .in_sb   (eta5),
    .out_vld (v_si),
    .root    (sini),
    .out_sb  (eta_si)
  );

  // ---- S6: Snell numerator sin_i * etai ----
  logic [43:0] num6;
  eta_t        eta6;
  logic        v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v_si;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num6 <= 44'(sini) * 44'(eta_si.etai);
      eta6 <= eta_si;
    end
  end

  // ---- transmitted sine = num / etat; etat >= 1.0 bounds the quotient ----
  logic [31:0] sint;
  eta_t        eta_st;
  logic        v_st;

  frl_div #(
    .DW  (EW),
    .SW  (31),
    .SBW ($bits(eta_t))
  ) u_div_snell (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v6),
    .den     (eta6.etat),
    .rem0    ({2'b00, num6[43:31]}),
    .low     (num6[30:0]),
    .in_sb   (eta6),
    .out_vld (v_st),
    .quo     (sint),
    .out_sb  (eta_st)
  );

  // ---- S7, S8: TIR test, 1 - sin_t^2 ----
  logic [59:0] sq7;
  logic [61:0] rad8;
  eta_t        eta7, eta8;
  logic        tir7, tir8, v7, v8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v7 <= v_st;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tir7 <= |sint[31:30];
      sq7  <= 60'(sint[29:0]) * 60'(sint[29:0]);
      eta7 <= eta_st;
      tir8 <= tir7;
      rad8 <= ONE_Q60 - {2'b00, sq7};
      eta8 <= eta7;
    end
  end

  // ---- transmitted cosine ----
  logic [CW-1:0] ct;
  eta_t          eta_ct;
  logic          tir_ct, v_ct;

  frl_isqrt #(
    .RW  (CW),
    .SBW ($bits(eta_t) + 1)
  ) u_sqrt_cos (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v8),
    .rad     (rad8),
    .in_sb   ({tir8, eta8}),
    .out_vld (v_ct),
    .root    (ct),
    .out_sb  ({tir_ct, eta_ct})
  );

  // ---- S9: eta*cos products, truncated to Q.30 ----
  logic [43:0] ps, qs, pp, qp;
  logic [31:0] a_s9, b_s9, a_p9, b_p9;
  logic        tir9, v9;

  assign ps = 44'(eta_ct.etat) * 44'(eta_ct.ci);
  assign qs = 44'(eta_ct.etai) * 44'(ct);
  assign pp = 44'(eta_ct.etai) * 44'(eta_ct.ci);
  assign qp = 44'(eta_ct.etat) * 44'(ct);

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v_ct;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_s9 <= ps[43:EFRAC];
      b_s9 <= qs[43:EFRAC];
      a_p9 <= pp[43:EFRAC];
      b_p9 <= qp[43:EFRAC];
      tir9 <= tir_ct;
    end
  end

  // ---- S10: denominators and numerator magnitudes ----
  logic [32:0] den_s_next, den_p_next, den_s10, den_p10;
  logic [31:0] d_s10, d_p10;
  logic        zero10, tir10, v10;

  assign den_s_next = 33'(a_s9) + 33'(b_s9);
  assign den_p_next = 33'(a_p9) + 33'(b_p9);

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_s10 <= den_s_next;
      den_p10 <= den_p_next;
      d_s10   <= (a_s9 >= b_s9) ? a_s9 - b_s9 : b_s9 - a_s9;
      d_p10   <= (a_p9 >= b_p9) ? a_p9 - b_p9 : b_p9 - a_p9;
      // grazing after truncation: forced to 1.0 downstream
      zero10  <= (den_s_next == '0) || (den_p_next == '0);
      tir10   <= tir9;
    end
  end

  // ---- Rs, Rp = |num| * 2^30 / den; |num| <= den keeps them <= 1.0 ----
  logic [CW-1:0] rs_q, rp_q;
  logic          vld_s, vld_p, tir_d, zero_d;

  frl_div #(
    .DW  (33),
    .SW  (CFRAC),
    .SBW (1)
  ) u_div_rs (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v10),
    .den     (den_s10),
    .rem0    ({2'b00, d_s10}),
    .low     ('0),
    .in_sb   (tir10),
    .out_vld (vld_s),
    .quo     (rs_q),
    .out_sb  (tir_d)
  );

  frl_div #(
    .DW  (33),
    .SW  (CFRAC),
    .SBW (1)
  ) u_div_rp (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v10),
    .den     (den_p10),
    .rem0    ({2'b00, d_p10}),
    .low     ('0),
    .in_sb   (zero10),
    .out_vld (vld_p),
    .quo     (rp_q),
    .out_sb  (zero_d)
  );

  // ---- S11: squares of the ratios, Q.60 ----
  logic [CW-1:0] rs_c, rp_c;
  logic [61:0]   sq_s11, sq_p11;
  logic          tir11, zero11, v11;

  assign rs_c = (rs_q > ONE_Q30) ? ONE_Q30 : rs_q;
  assign rp_c = (rp_q > ONE_Q30) ? ONE_Q30 : rp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else if (en) begin
      v11 <= vld_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_s11 <= 62'(rs_c) * 62'(rs_c);
      sq_p11 <= 62'(rp_c) * 62'(rp_c);
      tir11  <= tir_d;
      zero11 <= zero_d;
    end
  end

  // ---- S12: mean, round half up, saturate; into the output register ----
  logic [62:0] sum12;
  logic [63:0] kr12, krr, krc;
  out_word_t   res;

  always_comb begin
    sum12 = 63'(sq_s11) + 63'(sq_p11);
    kr12  = {2'b00, sum12[62:1]};
    krr   = (kr12 + HALF_LSB) >> RSH;
    krc   = (krr > ONE_OUT) ? ONE_OUT : krr;
    res.reflectance    = (tir11 || zero11) ? ONE_OUT[15:0] : krc[15:0];
    res.total_internal = tir11;
  end

  frl_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (v11),
    .in_word   (res),
    .ready     (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign in_ready = en;

  // ---- checks ----
  // the Rs and Rp dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst) vld_s == vld_p)
    else $error("Rs and Rp dividers out of step");

  // a full skid entry means the output register is also occupied
  a_skid_order: assert property (@(posedge clk) disable iff (rst) !in_ready |-> out_valid)
    else $error("skid entry full with empty output register");

  // total internal reflection always reports reflectance 1.0
  a_tir_one: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_word.total_internal |-> out_word.reflectance == ONE_OUT[15:0])
    else $error("total internal reflection without unit reflectance");

  // pipeline is open right after reset
  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("not ready after reset");

endmodule
